/* src/qdd_pkg.sv */
// Shared types and constants for the quadrature detent decoder with event queue.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package qdd_pkg;

  // Event queue size and the widths that follow from it.
  localparam int EVENT_DEPTH = 4;
  localparam int EV_IDX_W    = (EVENT_DEPTH > 1) ? $clog2(EVENT_DEPTH) : 1;
  localparam int EV_FILL_W   = $clog2(EVENT_DEPTH + 1);

  // Length of the phase history.
  localparam int HIST_LEN = 5;

  // Depth of the operation queue between the front and back parts.
  localparam int OPQ_DEPTH = 2;
  localparam int OPQ_PTR_W = $clog2(OPQ_DEPTH);
  localparam int OPQ_CNT_W = $clog2(OPQ_DEPTH + 1);

  // Stream payload widths.
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 8;
  localparam int QCOUNT_W    = 3;

  // Input commands.
  localparam logic [1:0] CMD_ROTARY = 2'd0;
  localparam logic [1:0] CMD_SWITCH = 2'd1;
  localparam logic [1:0] CMD_READ   = 2'd2;

  // Encoder phases, pin A in the high bit.
  localparam logic [1:0] PH_LL = 2'd0;
  localparam logic [1:0] PH_LH = 2'd1;
  localparam logic [1:0] PH_HL = 2'd2;
  localparam logic [1:0] PH_HH = 2'd3;

  // Event codes.
  localparam logic [1:0] EV_CW   = 2'd0;
  localparam logic [1:0] EV_CCW  = 2'd1;
  localparam logic [1:0] EV_DOWN = 2'd2;
  localparam logic [1:0] EV_UP   = 2'd3;

  typedef logic [1:0] phase_hist_t [HIST_LEN];

  // Detent patterns, newest phase first.
  localparam phase_hist_t CW_SEQ  = '{PH_HH, PH_HL, PH_LL, PH_LH, PH_HH};
  localparam phase_hist_t CCW_SEQ = '{PH_HH, PH_LH, PH_LL, PH_HL, PH_HH};

  // What the back part must do for one item.
  typedef enum logic [1:0] {
    OP_NONE,
    OP_PUSH,
    OP_POP
  } op_kind_e;

  typedef struct packed {
    op_kind_e   kind;
    logic [1:0] code;
  } op_t;

endpackage

`default_nettype wire

/* src/qdd_front.sv */
// Front part: accepts input items, tracks the encoder phase history and
// classifies each item into a queue operation. Depends on qdd_pkg.
`default_nettype none

module qdd_front import qdd_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  item_valid_i,
  input  wire logic [IN_TDATA_W-1:0] item_data_i,
  input  wire logic                  opq_full_i,
  output logic                       item_ready_o,
  output logic                       op_push_o,
  output op_t                        op_o
);

  logic [1:0]  command;
  logic [1:0]  phase;
  logic        switch_level;
  logic        accept;
  logic        phase_new;
  logic        cw_match;
  logic        ccw_match;
  phase_hist_t hist_q;
  phase_hist_t hist_d;

  // Unpack the item fields.
  assign command      = item_data_i[1:0];
  assign phase        = {item_data_i[2], item_data_i[3]};
  assign switch_level = item_data_i[4];

  assign item_ready_o = ~opq_full_i;
  assign accept       = item_valid_i & item_ready_o;
  assign op_push_o    = accept;

  // Shift the history when a rotary item brings a new phase.
  assign phase_new = (command == CMD_ROTARY) && (phase != hist_q[0]);

  always_comb begin
    hist_d    = hist_q;
    hist_d[0] = phase;
    for (int i = 1; i < HIST_LEN; i++) begin
      hist_d[i] = hist_q[i-1];
    end
  end

  // Compare the shifted history with both detent patterns.
  always_comb begin
    cw_match  = 1'b1;
    ccw_match = 1'b1;
    for (int i = 0; i < HIST_LEN; i++) begin
      if (hist_d[i] != CW_SEQ[i])  cw_match  = 1'b0;
      if (hist_d[i] != CCW_SEQ[i]) ccw_match = 1'b0;
    end
  end

  // Classify the item.
  always_comb begin
    op_o.kind = OP_NONE;
    op_o.code = EV_CW;
    case (command)
      CMD_ROTARY: begin
        if (phase_new && (phase == PH_HH)) begin
          if (cw_match) begin
            op_o.kind = OP_PUSH;
            op_o.code = EV_CW;
          end else if (ccw_match) begin
            op_o.kind = OP_PUSH;
            op_o.code = EV_CCW;
          end
        end
      end
      CMD_SWITCH: begin
        op_o.kind = OP_PUSH;
        op_o.code = switch_level ? EV_UP : EV_DOWN;
      end
      CMD_READ: begin
        op_o.kind = OP_POP;
      end
      default: begin
        op_o.kind = OP_NONE;
      end
    endcase
  end

  // Phase history register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < HIST_LEN; i++) begin
        hist_q[i] <= PH_LL;
      end
    end else if (accept && phase_new) begin
      hist_q <= hist_d;
    end
  end

endmodule

`default_nettype wire

/* src/qdd_op_fifo.sv */
// Short operation queue between the front and back parts.
// Depends on qdd_pkg for the operation type and depth.
`default_nettype none

module qdd_op_fifo import qdd_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  op_t       op_i,
  input  wire logic pop_i,
  output logic      full_o,
  output logic      valid_o,
  output op_t       op_o
);

  op_t                  mem_q [OPQ_DEPTH];
  logic [OPQ_PTR_W-1:0] wr_ptr_q;
  logic [OPQ_PTR_W-1:0] rd_ptr_q;
  logic [OPQ_CNT_W-1:0] count_q;
  logic                 do_push;
  logic                 do_pop;

  assign full_o  = (count_q == OPQ_CNT_W'(OPQ_DEPTH));
  assign valid_o = (count_q != '0);
  assign op_o    = mem_q[rd_ptr_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;

  // Storage; entries need no reset.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= op_i;
    end
  end

  // Pointers and occupancy.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == OPQ_PTR_W'(OPQ_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == OPQ_PTR_W'(OPQ_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

/* src/qdd_back.sv */
// Back part: carries out queue operations on the event queue and holds the
// result item in an output register. Depends on qdd_pkg.
`default_nettype none

module qdd_back import qdd_pkg::*; (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   op_valid_i,
  input  op_t                         op_i,
  output logic                        op_pop_o,
  output logic                        res_valid_o,
  input  wire logic                   res_ready_i,
  output logic [OUT_TDATA_W-1:0]      res_data_o
);

  localparam int SUM_W = EV_FILL_W + 1;

  logic [1:0]           event_queue [EVENT_DEPTH];
  logic [EV_IDX_W-1:0]  head_q;
  logic [EV_IDX_W-1:0]  head_d;
  logic [EV_FILL_W-1:0] fill_q;
  logic [EV_FILL_W-1:0] fill_d;
  logic [SUM_W-1:0]     tail_sum;
  logic [EV_IDX_W-1:0]  tail;
  logic                 take;
  logic                 full;
  logic                 wr_en;
  logic                 ev_valid;
  logic [1:0]           ev_code;
  logic                 dropped;
  logic                 res_valid_q;
  logic [OUT_TDATA_W-1:0] res_data_q;
  logic [OUT_TDATA_W-1:0] res_data_d;

  // Take an operation when the output register is free or being emptied.
  assign take     = op_valid_i & (~res_valid_q | res_ready_i);
  assign op_pop_o = take;
  assign full     = (fill_q == EV_FILL_W'(EVENT_DEPTH));

  // Write slot: head plus fill, wrapped once.
  always_comb begin
    tail_sum = SUM_W'(head_q) + SUM_W'(fill_q);
    if (tail_sum >= SUM_W'(EVENT_DEPTH)) begin
      tail_sum = tail_sum - SUM_W'(EVENT_DEPTH);
    end
    tail = tail_sum[EV_IDX_W-1:0];
  end

  // Execute the operation.
  always_comb begin
    head_d   = head_q;
    fill_d   = fill_q;
    wr_en    = 1'b0;
    ev_valid = 1'b0;
    ev_code  = EV_CW;
    dropped  = 1'b0;
    case (op_i.kind)
      OP_PUSH: begin
        if (full) begin
          dropped = 1'b1;
        end else begin
          wr_en  = 1'b1;
          fill_d = fill_q + 1'b1;
        end
      end
      OP_POP: begin
        if (fill_q != '0) begin
          ev_valid = 1'b1;
          ev_code  = event_queue[head_q];
          fill_d   = fill_q - 1'b1;
          head_d   = (head_q == EV_IDX_W'(EVENT_DEPTH - 1)) ? '0 : head_q + 1'b1;
        end
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  // Result packing: event_valid, event_code, dropped, queue_count.
  assign res_data_d = OUT_TDATA_W'({QCOUNT_W'(fill_d), dropped, ev_code, ev_valid});

  // Event storage; entries are only read after being written.
  always_ff @(posedge clk_i) begin
    if (take && wr_en) begin
      event_queue[tail] <= op_i.code;
    end
  end

  // Queue pointers and the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      fill_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      if (take) begin
        head_q      <= head_d;
        fill_q      <= fill_d;
        res_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      res_data_q <= res_data_d;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_data_o  = res_data_q;

endmodule

`default_nettype wire

/* src/quadrature_detent_decoder_event_queue_unit.sv */
// Top level of the quadrature detent decoder with event queue.
// Instantiates qdd_front, qdd_op_fifo and qdd_back; depends on qdd_pkg.
//
// Channel   Direction  Contents
// s_axis    in         pin change, switch change or read item
// m_axis    out        one result item per input item
//
// Each item passes the front part in its accept cycle and is written into the
// two-entry operation queue; the back part takes it from there and loads its
// result into the output register.
// One item is taken per cycle while m_axis_tready stays high; the event
// queue update in the back part is the step that sets it.
// A stall on m_axis fills the operation queue and then drops s_axis_tready.
// Reset clears the phase history to LL and empties both queues.
`default_nettype none

module quadrature_detent_decoder_event_queue_unit import qdd_pkg::*; (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  // [1:0] command, [2] clk_level, [3] dt_level, [4] switch_level
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  // [0] event_valid, [2:1] event_code, [3] dropped, [6:4] queue_count
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata
);

  logic opq_full;
  logic opq_push;
  logic opq_valid;
  logic opq_pop;
  op_t  front_op;
  op_t  back_op;

  // Accept and classify.
  qdd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (s_axis_tvalid),
    .item_data_i  (s_axis_tdata),
    .opq_full_i   (opq_full),
    .item_ready_o (s_axis_tready),
    .op_push_o    (opq_push),
    .op_o         (front_op)
  );

  // Decoupling queue.
  qdd_op_fifo u_op_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (opq_push),
    .op_i    (front_op),
    .pop_i   (opq_pop),
    .full_o  (opq_full),
    .valid_o (opq_valid),
    .op_o    (back_op)
  );

  // Event queue and result register.
  qdd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_valid_i  (opq_valid),
    .op_i        (back_op),
    .op_pop_o    (opq_pop),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_data_o  (m_axis_tdata)
  );

endmodule

`default_nettype wire
